>>> design/stick_radial_dead_zone_macros.svh
// assertion macros for the stick radial dead zone block
`ifndef STICK_RADIAL_DEAD_ZONE_MACROS_SVH
`define STICK_RADIAL_DEAD_ZONE_MACROS_SVH
`ifndef SYNTHESIS
`define SRDZ_ASSERT(lbl, ck, rstn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define SRDZ_ASSERT_ALWAYS(lbl, ck, prop) \
	lbl: assert property (@(posedge ck) prop) \
		else $error("assertion failed");
`else
`define SRDZ_ASSERT(lbl, ck, rstn, prop)
`define SRDZ_ASSERT_ALWAYS(lbl, ck, prop)
`endif
`endif

>>> design/srdz_pkg.sv
// shared types and constants of the stick radial dead zone block
package srdz_pkg;

	localparam int AXIS_W   = 16;
	localparam int MAG_W    = 16;
	localparam int SQ_W     = 32;
	localparam int ROOT_W   = 16;
	localparam int DZ_W     = 15;
	localparam int M_W      = 15;
	localparam int ADDR_W   = 2;
	localparam int DATA_W   = 32;
	localparam int OUT_FULL = 32767;
	localparam int DZ_RESET = 10813;

	localparam logic [ADDR_W-1:0] ADDR_DZ = '0;

	typedef struct packed {
		logic signed [AXIS_W-1:0] axis_x;
		logic signed [AXIS_W-1:0] axis_y;
		logic                     stick_select;
	} sample_t;

	typedef struct packed {
		logic signed [AXIS_W-1:0] vector_x;
		logic signed [AXIS_W-1:0] vector_y;
		logic                     outside_dead_zone;
		logic                     stick_id;
	} result_t;

endpackage

>>> design/srdz_sqrt.sv
// pipelined integer square root, one result bit per stage
module srdz_sqrt #(
	parameter int SIDE_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [srdz_pkg::SQ_W-1:0]   radicand,
	input  logic [SIDE_W-1:0]           in_side,
	output logic                        out_valid,
	output logic [srdz_pkg::ROOT_W-1:0] root,
	output logic [SIDE_W-1:0]           out_side
);
	import srdz_pkg::*;

	localparam int REM_W = ROOT_W + 3;

	logic              vld  [0:ROOT_W];
	logic [SQ_W-1:0]   rad  [0:ROOT_W];
	logic [REM_W-1:0]  rem  [0:ROOT_W];
	logic [ROOT_W-1:0] rt   [0:ROOT_W];
	logic [SIDE_W-1:0] side [0:ROOT_W];

	assign vld[0]  = in_valid;
	assign rad[0]  = radicand;
	assign rem[0]  = '0;
	assign rt[0]   = '0;
	assign side[0] = in_side;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
		logic [REM_W-1:0] rem_sh;
		logic [REM_W-1:0] trial;
		logic             ge;

		always_comb begin
			rem_sh = {rem[i][REM_W-3:0], rad[i][SQ_W-1:SQ_W-2]};
			trial  = {1'b0, rt[i], 2'b01};
			ge     = rem_sh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[i+1] <= 1'b0;
			end else begin
				vld[i+1] <= vld[i];
			end
		end

		always_ff @(posedge clk) begin
			rad[i+1]  <= {rad[i][SQ_W-3:0], 2'b00};
			rem[i+1]  <= ge ? (rem_sh - trial) : rem_sh;
			rt[i+1]   <= {rt[i][ROOT_W-2:0], ge};
			side[i+1] <= side[i];
		end
	end

	assign out_valid = vld[ROOT_W];
	assign root      = rt[ROOT_W];
	assign out_side  = side[ROOT_W];

endmodule

>>> design/srdz_div.sv
// pipelined restoring divider, one quotient bit per stage
module srdz_div #(
	parameter int DW     = 15,
	parameter int QW     = 15,
	parameter int SIDE_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [QW+DW-1:0]     dividend,
	input  logic [DW-1:0]        divisor,
	input  logic [SIDE_W-1:0]    in_side,
	output logic                 out_valid,
	output logic [QW-1:0]        quotient,
	output logic [SIDE_W-1:0]    out_side
);
	import srdz_pkg::*;

	// the dividend is below divisor times 2^QW, so its top bits start as the remainder
	logic              vld  [0:QW];
	logic [DW-1:0]     rem  [0:QW];
	logic [QW-1:0]     lo   [0:QW];
	logic [DW-1:0]     dv   [0:QW];
	logic [QW-1:0]     quo  [0:QW];
	logic [SIDE_W-1:0] side [0:QW];

	assign vld[0]  = in_valid;
	assign rem[0]  = dividend[QW+DW-1:QW];
	assign lo[0]   = dividend[QW-1:0];
	assign dv[0]   = divisor;
	assign quo[0]  = '0;
	assign side[0] = in_side;

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [DW:0] rem_sh;
		logic [DW:0] diff;
		logic        ge;

		always_comb begin
			rem_sh = {rem[i], lo[i][QW-1]};
			ge     = rem_sh >= {1'b0, dv[i]};
			diff   = rem_sh - {1'b0, dv[i]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[i+1] <= 1'b0;
			end else begin
				vld[i+1] <= vld[i];
			end
		end

		always_ff @(posedge clk) begin
			rem[i+1]  <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
			lo[i+1]   <= lo[i] << 1;
			dv[i+1]   <= dv[i];
			quo[i+1]  <= {quo[i][QW-2:0], ge};
			side[i+1] <= side[i];
		end
	end

	assign out_valid = vld[QW];
	assign quotient  = quo[QW];
	assign out_side  = side[QW];

endmodule

>>> design/stick_radial_dead_zone.sv
// the delay from the start cycle to the done strobe is the same whatever AXIS_BITS
// throughput: one item every cycle; busy stays low as nothing downstream can stall
// the depth comes from the 16-stage square root and two 15-stage dividers in series
// reset clears every valid bit and sets the dead-zone radius to 10813
// items in flight at reset are dropped
`include "stick_radial_dead_zone_macros.svh"
module stick_radial_dead_zone #(
	parameter int AXIS_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  srdz_pkg::sample_t           sample,
	output logic                        done,
	output srdz_pkg::result_t           result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [srdz_pkg::ADDR_W-1:0] paddr,
	input  logic [srdz_pkg::DATA_W-1:0] pwdata,
	output logic [srdz_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import srdz_pkg::*;

	localparam int SH    = AXIS_W - AXIS_BITS;
	localparam int FS    = 2 ** (AXIS_BITS - 1) - 1;
	localparam logic [SQ_W-1:0] FS_SQ = SQ_W'(FS * FS);
	localparam int DIV1_DW = DZ_W;
	localparam int DIV2_DW = ROOT_W;
	localparam int SQ_SIDE_W = 2 + 2 * MAG_W + 3;
	localparam int D1_SIDE_W = SQ_SIDE_W + 1 + ROOT_W;
	localparam int LAT = 3 + ROOT_W + 1 + M_W + 1 + M_W + 1;

	// configuration
	logic [DZ_W-1:0] dz_q;
	logic [DZ_W-1:0] dz_eff;
	logic [DZ_W-1:0] span;

	assign pready = 1'b1;
	assign busy   = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q <= DZ_W'(DZ_RESET);
		end else if (psel && penable && pwrite && paddr == ADDR_DZ) begin
			dz_q <= pwdata[DZ_W-1:0];
		end
	end

	assign prdata = (paddr == ADDR_DZ) ? DATA_W'(dz_q) : '0;
	assign dz_eff = (dz_q >= DZ_W'(FS)) ? DZ_W'(FS - 1) : dz_q;
	assign span   = DZ_W'(FS) - dz_eff;

	// stage 1: sign-extend the meaningful bits and take magnitudes
	logic signed [AXIS_W-1:0] shl_x, shl_y, ext_x, ext_y;
	logic [MAG_W-1:0]         mag_x_c, mag_y_c;

	always_comb begin
		shl_x   = sample.axis_x <<< SH;
		shl_y   = sample.axis_y <<< SH;
		ext_x   = shl_x >>> SH;
		ext_y   = shl_y >>> SH;
		mag_x_c = ext_x[AXIS_W-1] ? (~unsigned'(ext_x) + 1'b1) : unsigned'(ext_x);
		mag_y_c = ext_y[AXIS_W-1] ? (~unsigned'(ext_y) + 1'b1) : unsigned'(ext_y);
	end

	logic             v_s1, sgn_x_s1, sgn_y_s1, stk_s1;
	logic [MAG_W-1:0] mag_x_s1, mag_y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		sgn_x_s1 <= ext_x[AXIS_W-1];
		sgn_y_s1 <= ext_y[AXIS_W-1];
		mag_x_s1 <= mag_x_c;
		mag_y_s1 <= mag_y_c;
		stk_s1   <= sample.stick_select;
	end

	// stage 2: squares
	logic [SQ_W-1:0]  sq_x_c, sq_y_c, sq_x_s2, sq_y_s2;
	logic             v_s2, sgn_x_s2, sgn_y_s2, stk_s2;
	logic [MAG_W-1:0] mag_x_s2, mag_y_s2;

	assign sq_x_c = mag_x_s1 * mag_x_s1;
	assign sq_y_c = mag_y_s1 * mag_y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sq_x_s2  <= sq_x_c;
		sq_y_s2  <= sq_y_c;
		sgn_x_s2 <= sgn_x_s1;
		sgn_y_s2 <= sgn_y_s1;
		mag_x_s2 <= mag_x_s1;
		mag_y_s2 <= mag_y_s1;
		stk_s2   <= stk_s1;
	end

	// stage 3: squared radius, full-scale and centre flags
	logic [SQ_W-1:0]      r2_c, r2_s3;
	logic                 v_s3;
	logic [SQ_SIDE_W-1:0] side_s3;

	assign r2_c = sq_x_s2 + sq_y_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		r2_s3   <= r2_c;
		side_s3 <= {sgn_x_s2, sgn_y_s2, mag_x_s2, mag_y_s2, stk_s2,
			r2_c > FS_SQ, r2_c == '0};
	end

	// square root
	logic                 v_rt;
	logic [ROOT_W-1:0]    root;
	logic [SQ_SIDE_W-1:0] side_rt;

	srdz_sqrt #(.SIDE_W(SQ_SIDE_W)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s3),
		.radicand (r2_s3),
		.in_side  (side_s3),
		.out_valid(v_rt),
		.root     (root),
		.out_side (side_rt)
	);

	// stage 4: dead-zone test and stretch numerator
	logic            rt_sat, rt_active;
	logic [M_W-1:0]  num;
	logic [ROOT_W-1:0] num_w;

	always_comb begin
		rt_sat    = side_rt[1];
		rt_active = root >= ROOT_W'(dz_eff);
		num_w     = root - ROOT_W'(dz_eff);
		num       = (!rt_sat && rt_active) ? num_w[M_W-1:0] : '0;
	end

	logic                    v_s4;
	logic [M_W+DIV1_DW-1:0]  dvd_s4;
	logic [DIV1_DW-1:0]      span_s4;
	logic [D1_SIDE_W-1:0]    side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_rt;
		end
	end

	// num times full scale as a shift and subtract
	always_ff @(posedge clk) begin
		dvd_s4  <= {num, {DZ_W{1'b0}}} - (M_W+DIV1_DW)'(num);
		span_s4 <= span;
		side_s4 <= {side_rt, rt_active, root};
	end

	logic                 v_d1;
	logic [M_W-1:0]       m_q;
	logic [D1_SIDE_W-1:0] side_d1;

	srdz_div #(.DW(DIV1_DW), .QW(M_W), .SIDE_W(D1_SIDE_W)) u_div_mag (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s4),
		.dividend (dvd_s4),
		.divisor  (span_s4),
		.in_side  (side_s4),
		.out_valid(v_d1),
		.quotient (m_q),
		.out_side (side_d1)
	);

	// stage 5: axis magnitude times stretched magnitude
	logic             d1_sgn_x, d1_sgn_y, d1_stk, d1_sat, d1_zero, d1_active;
	logic [MAG_W-1:0] d1_mag_x, d1_mag_y;
	logic [ROOT_W-1:0] d1_root;
	logic [M_W-1:0]   mag_m;

	assign {d1_sgn_x, d1_sgn_y, d1_mag_x, d1_mag_y, d1_stk, d1_sat, d1_zero,
		d1_active, d1_root} = side_d1;
	assign mag_m = d1_sat ? M_W'(OUT_FULL) : m_q;

	logic                    v_s5;
	logic [M_W+DIV2_DW-1:0]  prod_x_c, prod_y_c, prod_x_s5, prod_y_s5;
	logic [DIV2_DW-1:0]      rdiv_s5;
	logic [3:0]              side_x_s5;
	logic                    side_y_s5;

	assign prod_x_c = d1_mag_x * mag_m;
	assign prod_y_c = d1_mag_y * mag_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_d1;
		end
	end

	// a centred stick has zero magnitudes, so any non-zero divisor will do
	always_ff @(posedge clk) begin
		prod_x_s5 <= prod_x_c;
		prod_y_s5 <= prod_y_c;
		rdiv_s5   <= d1_zero ? DIV2_DW'(1) : d1_root;
		side_x_s5 <= {d1_sgn_x, d1_stk, d1_active, d1_zero};
		side_y_s5 <= d1_sgn_y;
	end

	logic           v_dx, v_dy;
	logic [M_W-1:0] q_x, q_y;
	logic [3:0]     side_dx;
	logic           side_dy;

	srdz_div #(.DW(DIV2_DW), .QW(M_W), .SIDE_W(4)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s5),
		.dividend (prod_x_s5),
		.divisor  (rdiv_s5),
		.in_side  (side_x_s5),
		.out_valid(v_dx),
		.quotient (q_x),
		.out_side (side_dx)
	);

	srdz_div #(.DW(DIV2_DW), .QW(M_W), .SIDE_W(1)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s5),
		.dividend (prod_y_s5),
		.divisor  (rdiv_s5),
		.in_side  (side_y_s5),
		.out_valid(v_dy),
		.quotient (q_y),
		.out_side (side_dy)
	);

	// output stage: restore signs, zero inside the dead zone
	logic                     o_sgn_x, o_stk, o_active, o_zero, o_live;
	logic signed [AXIS_W-1:0] qx_s, qy_s, vx_c, vy_c;
	logic                     done_s6;
	result_t                  result_s6;

	always_comb begin
		{o_sgn_x, o_stk, o_active, o_zero} = side_dx;
		o_live = o_active && !o_zero;
		qx_s   = signed'({1'b0, q_x});
		qy_s   = signed'({1'b0, q_y});
		vx_c   = !o_live ? '0 : (o_sgn_x ? -qx_s : qx_s);
		vy_c   = !o_live ? '0 : (side_dy ? -qy_s : qy_s);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s6 <= 1'b0;
		end else begin
			done_s6 <= v_dx && v_dy;
		end
	end

	always_ff @(posedge clk) begin
		result_s6.vector_x          <= vx_c;
		result_s6.vector_y          <= vy_c;
		result_s6.outside_dead_zone <= o_active;
		result_s6.stick_id          <= o_stk;
	end

	assign done   = done_s6;
	assign result = result_s6;

	`SRDZ_ASSERT(a_latency, clk, arst_n, start && !busy |-> ##LAT done)
	`SRDZ_ASSERT(a_dead_zero, clk, arst_n, done && !result.outside_dead_zone |-> result.vector_x == '0 && result.vector_y == '0)
	`SRDZ_ASSERT(a_no_min, clk, arst_n, done |-> result.vector_x != 16'h8000 && result.vector_y != 16'h8000)
	`SRDZ_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> !done)

endmodule
